/* hdl/mcfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcfd_pkg
// Shared types and constants for the motor command frame decoder: character
// codes, status codes, frame state and result records.
// ----------------------------------------------------------------------------
package mcfd_pkg;

    // frame geometry
    localparam int unsigned FRAME_CHARS = 7;
    localparam int unsigned POS_W       = 4;
    localparam logic [POS_W-1:0] POS_MAX      = 4'd15;
    localparam logic [POS_W-1:0] POS_FRAME_END = POS_W'(FRAME_CHARS);

    // character positions within a frame
    localparam logic [POS_W-1:0] POS_SPEED_HI  = 4'd0;
    localparam logic [POS_W-1:0] POS_SPEED_MID = 4'd1;
    localparam logic [POS_W-1:0] POS_SPEED_LO  = 4'd2;
    localparam logic [POS_W-1:0] POS_DRIVE     = 4'd3;
    localparam logic [POS_W-1:0] POS_ANGLE_HI  = 4'd4;
    localparam logic [POS_W-1:0] POS_ANGLE_LO  = 4'd5;
    localparam logic [POS_W-1:0] POS_STEER     = 4'd6;

    // terminator reset value, upper-case 'E'
    localparam logic [7:0] END_CHAR_RESET = 8'h45;

    // ascii codes
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_FOUR    = 8'h34;
    localparam logic [7:0] CH_FIVE    = 8'h35;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_UP_B    = 8'h42;
    localparam logic [7:0] CH_LO_B    = 8'h62;
    localparam logic [7:0] CH_UP_R    = 8'h52;
    localparam logic [7:0] CH_LO_R    = 8'h72;
    localparam logic [7:0] CH_UP_L    = 8'h4C;
    localparam logic [7:0] CH_LO_L    = 8'h6C;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LENGTH  = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    // partial frame state
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             bad;
        logic [7:0]       speed;
        logic [5:0]       angle;
        logic             fwd;
        logic             right;
    } frame_t;

    // one decoded result beat
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] speed;
        logic       forward;
        logic [5:0] angle;
        logic       steer_right;
    } result_t;

endpackage
`default_nettype wire

/* hdl/mcfd_char_check.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcfd_char_check
// Per-byte decode: terminator detection, position check, accumulator update
// and result formation. Purely combinational.
// ----------------------------------------------------------------------------
module mcfd_char_check
(
    input  wire logic [7:0]       rx_char,
    input  wire logic [7:0]       end_char,
    input  wire mcfd_pkg::frame_t frame,
    output mcfd_pkg::frame_t      frame_next,
    output logic                  term,
    output mcfd_pkg::result_t     result
);
    import mcfd_pkg::*;

    logic [7:0] end_lower;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_fwd;
    logic       is_back;
    logic       is_right;
    logic       is_left;
    logic       char_ok;
    logic [7:0] speed_x10;
    logic [5:0] angle_x10;

    // terminator, lower-case form only for letters
    always_comb
    begin
        end_lower = end_char;
        if (end_char >= CH_UP_A && end_char <= CH_UP_Z)
        begin
            end_lower = end_char | CASE_BIT;
        end
        term = (rx_char == end_char) || (rx_char == end_lower);
    end

    // character classes
    assign is_digit = (rx_char >= CH_ZERO);
    assign digit    = rx_char[3:0];
    assign is_fwd   = (rx_char == CH_UP_F) || (rx_char == CH_LO_F);
    assign is_back  = (rx_char == CH_UP_B) || (rx_char == CH_LO_B);
    assign is_right = (rx_char == CH_UP_R) || (rx_char == CH_LO_R);
    assign is_left  = (rx_char == CH_UP_L) || (rx_char == CH_LO_L);

    // times ten as two shifts and an add
    assign speed_x10 = {frame.speed[4:0], 3'b000} + {frame.speed[6:0], 1'b0};
    assign angle_x10 = {frame.angle[2:0], 3'b000} + {frame.angle[4:0], 1'b0};

    // validity of the byte for its position
    always_comb
    begin
        unique case (frame.pos)
            POS_SPEED_HI:                char_ok = is_digit && (rx_char <= CH_ONE);
            POS_SPEED_MID, POS_SPEED_LO: char_ok = is_digit && (rx_char <= CH_NINE);
            POS_DRIVE:                   char_ok = is_fwd || is_back;
            POS_ANGLE_HI:                char_ok = is_digit && (rx_char <= CH_FOUR);
            POS_ANGLE_LO:                char_ok = is_digit && (rx_char <= CH_FIVE);
            POS_STEER:                   char_ok = is_right || is_left;
            default:                     char_ok = 1'b1;
        endcase
    end

    // next frame state for a non-terminator byte
    always_comb
    begin
        frame_next = frame;
        if (frame.pos < POS_FRAME_END)
        begin
            if (!char_ok)
            begin
                frame_next.bad = 1'b1;
            end
            else if (frame.pos <= POS_SPEED_LO)
            begin
                frame_next.speed = speed_x10 + {4'b0000, digit};
            end
            else if (frame.pos == POS_DRIVE)
            begin
                frame_next.fwd = is_fwd;
            end
            else if (frame.pos <= POS_ANGLE_LO)
            begin
                frame_next.angle = angle_x10 + {2'b00, digit};
            end
            else
            begin
                frame_next.right = is_right;
            end
        end
        if (frame.pos != POS_MAX)
        begin
            frame_next.pos = frame.pos + 1'b1;
        end
    end

    // result on terminator, length error wins over bad character
    always_comb
    begin
        result = '0;
        priority if (frame.pos != POS_FRAME_END)
        begin
            result.status = ST_LENGTH;
        end
        else if (frame.bad)
        begin
            result.status = ST_BAD;
        end
        else
        begin
            result.status      = ST_OK;
            result.speed       = frame.speed;
            result.forward     = frame.fwd;
            result.angle       = frame.angle;
            result.steer_right = frame.right;
        end
    end

endmodule
`default_nettype wire

/* hdl/motor_command_frame_decoder_core.sv */
// A taken terminator's result goes to the output register, or to the skid
// entry while the output is stalled. Throughput: one byte per cycle while the
// skid entry is empty; frame state is registered in the cycle a byte is taken.
// A two-entry output register and skid stage keep input flowing while a result
// is stalled; input stalls only while the skid entry is occupied.
// Reset clears the frame state and both output entries; end_char returns to 'E'.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_command_frame_decoder_core
// Decodes seven-character motor command frames from a byte stream and emits
// one status/value result beat per terminator.
// ----------------------------------------------------------------------------
module motor_command_frame_decoder_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] end_char,
    // received bytes
    input  wire logic       rx_valid,
    output logic            rx_stall,
    input  wire logic [7:0] rx_char,
    // result beats
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      status,
    output logic [7:0]      speed,
    output logic            forward,
    output logic [5:0]      angle,
    output logic            steer_right
);
    import mcfd_pkg::*;

    logic [7:0] end_char_reg;
    frame_t     frame_reg;
    frame_t     frame_next;
    logic       term;
    result_t    result;
    logic       rx_fire;
    logic       new_res;
    logic       out_valid_reg;
    result_t    out_data_reg;
    logic       skid_valid_reg;
    result_t    skid_data_reg;

    // per-byte decode
    mcfd_char_check u_check
    (
        .rx_char    (rx_char),
        .end_char   (end_char_reg),
        .frame      (frame_reg),
        .frame_next (frame_next),
        .term       (term),
        .result     (result)
    );

    assign cfg_ready = 1'b1;
    assign rx_stall  = skid_valid_reg;
    assign rx_fire   = rx_valid && !rx_stall;
    assign new_res   = rx_fire && term;

    // terminator register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_char_reg <= END_CHAR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            end_char_reg <= end_char;
        end
    end

    // frame state, cleared after every terminator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else if (rx_fire)
        begin
            frame_reg <= term ? frame_t'('0) : frame_next;
        end
    end

    // output register and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= new_res;
            end
        end
        else if (new_res)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (new_res)
        begin
            skid_data_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_data_reg.status;
    assign speed       = out_data_reg.speed;
    assign forward     = out_data_reg.forward;
    assign angle       = out_data_reg.angle;
    assign steer_right = out_data_reg.steer_right;

    // skid entry only fills behind a held output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied with empty output register");

    // after a taken terminator the output register always holds a valid beat next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        new_res |=> out_valid_reg)
        else $error("terminator did not produce a result beat");

    // frame state restarts after a terminator
    assert property (@(posedge clk) disable iff (!rst_n)
        new_res |=> (frame_reg.pos == '0 && !frame_reg.bad))
        else $error("frame state not cleared after terminator");

    // failed frames carry zero values
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status != ST_OK) |->
            (speed == '0 && angle == '0 && !forward && !steer_right))
        else $error("failed frame carries non-zero values");

endmodule
`default_nettype wire
